@@ design/vdl_pkg.sv @@
// Package for the vertex diffuse lighting core: sizes, register codes, types.
// No dependencies; the length unit, the weight pipe and the core import it.
`default_nettype none
package vdl_pkg;
	localparam int NUM_LIGHTS  = 3;
	localparam int LIGHT_SLOTS = 3;
	localparam int ADDR_W      = 6;
	localparam int DATA_W      = 64;
	localparam int REG_W       = 48;
	localparam int LEN_W       = 31;
	localparam int NUM_W       = 48;
	localparam int W_W         = 15;
	localparam int QBITS       = 14;
	localparam int DIV_STAGES  = 7;
	localparam int WPIPE_LAT   = 11;
	localparam logic [W_W-1:0] W_ONE = W_W'(16384);

	typedef enum logic [2:0] {
		REG_AMBIENT = 3'd0,
		REG_L0_DIR  = 3'd1,
		REG_L0_DIF  = 3'd2,
		REG_L1_DIR  = 3'd3,
		REG_L1_DIF  = 3'd4,
		REG_L2_DIR  = 3'd5,
		REG_L2_DIF  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [QBITS-1:0] q;
		logic             sat;
		logic             zero;
	} div_t;

	typedef struct packed {
		logic signed [15:0] em_r;
		logic signed [15:0] em_g;
		logic signed [15:0] em_b;
		logic [31:0]        vc;
		logic signed [15:0] scale;
	} aux_t;

	function automatic logic signed [15:0] lane(input logic [REG_W-1:0] r, input int k);
		lane = r[16*k +: 16];
	endfunction
endpackage
`default_nettype wire

@@ design/vdl_if.sv @@
// Valid/ready channel interfaces for vertex items and packed colour results.
// Depends on nothing.
`default_nettype none
interface vdl_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic signed [15:0] emissive_r;
	logic signed [15:0] emissive_g;
	logic signed [15:0] emissive_b;
	logic [31:0]        vertex_color;
	logic signed [15:0] scale;
	modport source (output valid, normal_x, normal_y, normal_z, emissive_r, emissive_g,
		emissive_b, vertex_color, scale, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, emissive_r, emissive_g,
		emissive_b, vertex_color, scale, output ready);
endinterface

interface vdl_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] argb;
	modport source (output valid, argb, input ready);
	modport sink (input valid, argb, output ready);
endinterface
`default_nettype wire

@@ design/vdl_len_unit.sv @@
// Sequential length unit: floor(sqrt(|dir|^2 << 30)) per light, one root bit a cycle.
// Depends on vdl_pkg.
`default_nettype none
module vdl_len_unit import vdl_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [LIGHT_SLOTS-1:0] dir_wr,
	input  wire logic [REG_W-1:0]       dir [LIGHT_SLOTS],
	output logic [LEN_W-1:0]            len [LIGHT_SLOTS],
	output logic [LIGHT_SLOTS-1:0]      zero,
	output logic                        busy
);
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SUMSQ = 3'b010,
		ST_ROOT  = 3'b100
	} st_t;

	st_t                    st_q;
	logic [LIGHT_SLOTS-1:0] pend_q;
	logic [LIGHT_SLOTS-1:0] pick;
	logic [1:0]             slot_q;
	logic [1:0]             k_q;
	logic [32:0]            l2_q;
	logic [63:0]            v_q;
	logic [63:0]            r_q;
	logic [63:0]            b_q;
	logic [63:0]            rb;
	logic signed [15:0]     c;
	logic signed [31:0]     sq;
	logic [32:0]            l2_sum;
	logic [1:0]             pick_idx;

	always_comb begin
		pick = '0;
		pick_idx = '0;
		for (int i = LIGHT_SLOTS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				pick = '0;
				pick[i] = 1'b1;
				pick_idx = 2'(i);
			end
		end
	end

	assign c      = lane(dir[slot_q], int'(k_q));
	assign sq     = c * c;
	assign l2_sum = l2_q + {1'b0, sq};
	assign rb     = r_q + b_q;
	assign busy   = (st_q != ST_IDLE) || (pend_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			pend_q <= '0;
			slot_q <= '0;
			k_q    <= '0;
			zero   <= '1;
			for (int i = 0; i < LIGHT_SLOTS; i++) len[i] <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (pend_q != '0) begin
						pend_q <= (pend_q & ~pick) | dir_wr;
						slot_q <= pick_idx;
						k_q    <= '0;
						l2_q   <= '0;
						st_q   <= ST_SUMSQ;
					end else begin
						pend_q <= pend_q | dir_wr;
					end
				end
				ST_SUMSQ: begin
					pend_q <= pend_q | dir_wr;
					l2_q   <= l2_sum;
					k_q    <= k_q + 2'd1;
					if (k_q == 2'd2) begin
						v_q  <= {1'b0, l2_sum, 30'b0};
						r_q  <= '0;
						b_q  <= 64'h4000_0000_0000_0000;
						zero[slot_q] <= (l2_sum == '0);
						st_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					pend_q <= pend_q | dir_wr;
					if (v_q >= rb) begin
						v_q <= v_q - rb;
						r_q <= (r_q >> 1) + b_q;
					end else begin
						r_q <= r_q >> 1;
					end
					b_q <= b_q >> 2;
					if (b_q == 64'd1) begin
						len[slot_q] <= (v_q >= rb) ? LEN_W'((r_q >> 1) + b_q)
							: LEN_W'(r_q >> 1);
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ design/vdl_weight_pipe.sv @@
// Per-light weight pipeline: dot product, |d|<<15 / len in 2-bit steps, clamp to 1.0.
// Depends on vdl_pkg.
`default_nettype none
module vdl_weight_pipe import vdl_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [15:0] nx,
	input  wire logic signed [15:0] ny,
	input  wire logic signed [15:0] nz,
	input  wire logic [REG_W-1:0]   dir,
	input  wire logic [LEN_W-1:0]   len,
	input  wire logic               dir_zero,
	output logic [W_W-1:0]          w
);
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic signed [33:0] d;
	logic [33:0]        dabs;
	logic [NUM_W-1:0]   num_s2;
	logic [NUM_W-1:0]   len_w;
	div_t               stg [DIV_STAGES+1];
	div_t               nxt [DIV_STAGES];

	assign d     = 34'(px_s1) + 34'(py_s1) + 34'(pz_s1);
	assign dabs  = d[33] ? 34'(-d) : d;
	assign len_w = NUM_W'(len);

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= lane(dir, 0) * nx;
			py_s1  <= lane(dir, 1) * ny;
			pz_s1  <= lane(dir, 2) * nz;
			num_s2 <= NUM_W'({dabs, 15'b0});
			stg[0].rem  <= num_s2;
			stg[0].q    <= '0;
			stg[0].sat  <= num_s2 >= (len_w << QBITS);
			stg[0].zero <= dir_zero;
		end
	end

	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
		always_comb begin
			nxt[s] = stg[s];
			for (int j = 1; j >= 0; j--) begin
				if (nxt[s].rem >= (len_w << (2 * (DIV_STAGES - 1 - s) + j))) begin
					nxt[s].rem = nxt[s].rem - (len_w << (2 * (DIV_STAGES - 1 - s) + j));
					nxt[s].q[2 * (DIV_STAGES - 1 - s) + j] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) stg[s+1] <= nxt[s];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (stg[DIV_STAGES].zero) w <= '0;
			else if (stg[DIV_STAGES].sat) w <= W_ONE;
			else w <= W_W'(stg[DIV_STAGES].q);
		end
	end
endmodule
`default_nettype wire

@@ design/vertex_diffuse_lighting_core.sv @@
// Vertex diffuse lighting core: config registers, weight pipes, colour pipeline.
// Depends on vdl_pkg, vdl_if, vdl_len_unit and vdl_weight_pipe.
//
// Usage:
//  vtx carries one vertex per transaction (normal, emissive, vertex colour, scale);
//  res carries one packed ARGB colour per vertex, in order.
//  Registers are 64-bit APB words at 8*index; writes take effect at the access
//  cycle. Writing a light direction starts the length unit, which holds vtx.ready
//  low while it works on each direction written (3 squares, then 32 root bits).
//  One vertex per cycle is sustained while res is not stalled and the length unit
//  is idle, set by the fully pipelined 11-stage weight path per light.
//  After reset all registers are zero and the pipeline is empty.
//  When res is stalled the whole pipeline holds and vtx.ready drops; nothing is
//  lost or repeated.
`default_nettype none
module vertex_diffuse_lighting_core import vdl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	vdl_in_if.sink                 vtx,
	vdl_out_if.source              res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);
	localparam int NSTG = WPIPE_LAT + 5;

	logic [REG_W-1:0]       amb_q;
	logic [REG_W-1:0]       dir_q [LIGHT_SLOTS];
	logic [REG_W-1:0]       dif_q [LIGHT_SLOTS];
	logic [LIGHT_SLOTS-1:0] dir_wr;
	logic [LEN_W-1:0]       len [LIGHT_SLOTS];
	logic [LIGHT_SLOTS-1:0] dzero;
	logic                   busy;
	logic                   wr;
	logic [2:0]             idx;
	logic                   en;
	logic                   acc_in;
	logic [NSTG-1:0]        v_q;
	logic [W_W-1:0]         w [NUM_LIGHTS];
	aux_t                   aux [WPIPE_LAT];
	aux_t                   aux_s12, aux_s13;
	logic signed [17:0]     ctb_s12 [NUM_LIGHTS][3];
	logic signed [20:0]     acc_s13 [3];
	logic signed [20:0]     acc [3];
	logic signed [31:0]     prod [NUM_LIGHTS][3];
	logic signed [31:0]     shf [NUM_LIGHTS][3];
	logic signed [8:0]      m [3];
	logic signed [29:0]     pm_s14 [3];
	logic signed [15:0]     sc_s14;
	logic signed [45:0]     p_s15 [3];
	logic [7:0]             byt [3];
	logic [31:0]            argb_q;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amb_q <= '0;
			for (int i = 0; i < LIGHT_SLOTS; i++) begin
				dir_q[i] <= '0;
				dif_q[i] <= '0;
			end
		end else if (wr) begin
			unique case (idx)
				REG_AMBIENT: amb_q    <= pwdata[REG_W-1:0];
				REG_L0_DIR:  dir_q[0] <= pwdata[REG_W-1:0];
				REG_L0_DIF:  dif_q[0] <= pwdata[REG_W-1:0];
				REG_L1_DIR:  dir_q[1] <= pwdata[REG_W-1:0];
				REG_L1_DIF:  dif_q[1] <= pwdata[REG_W-1:0];
				REG_L2_DIR:  dir_q[2] <= pwdata[REG_W-1:0];
				REG_L2_DIF:  dif_q[2] <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		dir_wr = '0;
		prdata = '0;
		unique case (idx)
			REG_AMBIENT: prdata = DATA_W'(amb_q);
			REG_L0_DIR: begin
				prdata = DATA_W'(dir_q[0]);
				dir_wr[0] = wr;
			end
			REG_L0_DIF:  prdata = DATA_W'(dif_q[0]);
			REG_L1_DIR: begin
				prdata = DATA_W'(dir_q[1]);
				dir_wr[1] = wr;
			end
			REG_L1_DIF:  prdata = DATA_W'(dif_q[1]);
			REG_L2_DIR: begin
				prdata = DATA_W'(dir_q[2]);
				dir_wr[2] = wr;
			end
			REG_L2_DIF:  prdata = DATA_W'(dif_q[2]);
			default: ;
		endcase
	end

	vdl_len_unit u_len (
		.clk    (clk),
		.arst_n (arst_n),
		.dir_wr (dir_wr),
		.dir    (dir_q),
		.len    (len),
		.zero   (dzero),
		.busy   (busy)
	);

	assign en        = !res.valid || res.ready;
	assign vtx.ready = en && !busy;
	assign acc_in    = vtx.valid && vtx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[NSTG-2:0], acc_in};
	end

	for (genvar i = 0; i < NUM_LIGHTS; i++) begin : g_light
		vdl_weight_pipe u_wp (
			.clk      (clk),
			.en       (en),
			.nx       (vtx.normal_x),
			.ny       (vtx.normal_y),
			.nz       (vtx.normal_z),
			.dir      (dir_q[i]),
			.len      (len[i]),
			.dir_zero (dzero[i]),
			.w        (w[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aux[0] <= '{em_r: vtx.emissive_r, em_g: vtx.emissive_g, em_b: vtx.emissive_b,
				vc: vtx.vertex_color, scale: vtx.scale};
			for (int s = 1; s < WPIPE_LAT; s++) aux[s] <= aux[s-1];
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_LIGHTS; i++) begin
			for (int k = 0; k < 3; k++) begin
				prod[i][k] = $signed({1'b0, w[i]}) * lane(dif_q[i], k);
				shf[i][k]  = prod[i][k] >>> 14;
			end
		end
	end

	always_comb begin
		acc[0] = 21'(lane(amb_q, 0)) + 21'(aux_s12.em_r);
		acc[1] = 21'(lane(amb_q, 1)) + 21'(aux_s12.em_g);
		acc[2] = 21'(lane(amb_q, 2)) + 21'(aux_s12.em_b);
		for (int i = 0; i < NUM_LIGHTS; i++) begin
			for (int k = 0; k < 3; k++) acc[k] = acc[k] + 21'(ctb_s12[i][k]);
		end
		if (aux_s13.vc != 32'hFFFF_FFFF) begin
			m[0] = $signed({1'b0, aux_s13.vc[23:16]});
			m[1] = $signed({1'b0, aux_s13.vc[15:8]});
			m[2] = $signed({1'b0, aux_s13.vc[7:0]});
		end else begin
			for (int k = 0; k < 3; k++) m[k] = 9'sd255;
		end
		for (int k = 0; k < 3; k++) begin
			if (p_s15[k] <= 0) byt[k] = '0;
			else if (p_s15[k][45:32] != '0) byt[k] = 8'hFF;
			else byt[k] = p_s15[k][31:24];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aux_s12 <= aux[WPIPE_LAT-1];
			for (int i = 0; i < NUM_LIGHTS; i++) begin
				for (int k = 0; k < 3; k++) ctb_s12[i][k] <= shf[i][k][17:0];
			end
			aux_s13 <= aux_s12;
			for (int k = 0; k < 3; k++) begin
				acc_s13[k] <= acc[k];
				pm_s14[k]  <= acc_s13[k] * m[k];
				p_s15[k]   <= pm_s14[k] * sc_s14;
			end
			sc_s14 <= aux_s13.scale;
			argb_q <= {8'hFF, byt[0], byt[1], byt[2]};
		end
	end

	assign res.valid = v_q[NSTG-1];
	assign res.argb  = argb_q;

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vtx.valid && vtx.ready |-> !busy)
		else $error("vertex accepted while light length is being computed");
	a_dir_write_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(dir_wr != '0) |=> !vtx.ready)
		else $error("input not held off after direction write");
	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(v_q[NSTG-2]))
		else $error("result appeared without a preceding stage");
`endif
endmodule
`default_nettype wire
